>>> rtl/core/wsps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the window surface pixel shader.
package wsps_pkg;

    // Input item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SHADE = 1'b1;

    // Title strip colours and geometry
    localparam logic [23:0] STRIP_LIGHT = 24'hF5F5FA;
    localparam logic [23:0] STRIP_DARK  = 24'h1C2028;
    localparam logic [3:0]  STRIP_FULL  = 4'd12;
    localparam logic [12:0] STRIP_LIMIT = 13'd14;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_WIN_LEFT      = 3'd0,
        REG_WIN_TOP       = 3'd1,
        REG_WIN_WIDTH     = 3'd2,
        REG_WIN_HEIGHT    = 3'd3,
        REG_IS_FOCUSED    = 3'd4,
        REG_BORDER_COLOUR = 3'd5,
        REG_FOCUS_COLOUR  = 3'd6
    } cfg_reg_t;

    // Work kinds handed from front to back
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEXEL = 2'd1,
        OP_FLAT  = 2'd2
    } op_t;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] width;
        logic [12:0] height;
        logic        focused;
        logic [23:0] border;
        logic [23:0] focus;
    } win_cfg_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] x;
        logic [11:0] y;
        logic        rend;
        logic [23:0] colour;
        logic [10:0] tidx;
        logic [11:0] rx;
        logic [11:0] ry;
    } mid_item_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] colour;
        logic        rend;
    } res_t;

endpackage

>>> rtl/core/wsps_fifo.sv
`timescale 1ns / 1ps
// Small register FIFO with a combinational head read.
module wsps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_mem [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[wr_ptr_reg] <= wdata;
        end
    end

    // Occupancy never exceeds the storage.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("fifo count beyond depth");

endmodule

>>> rtl/core/wsps_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, clips to the window and classifies each pixel.
module wsps_front (
    input  logic                 push,
    output logic                 full,
    input  logic                 kind,
    input  logic [10:0]          texel_index,
    input  logic [23:0]          texel_colour,
    input  logic [11:0]          pixel_x,
    input  logic [11:0]          pixel_y,
    input  logic                 region_end,
    input  wsps_pkg::win_cfg_t   win_cfg,
    input  logic [12:0]          inner_h,
    input  logic                 q_full,
    output logic                 q_push,
    output wsps_pkg::mid_item_t  q_item
);

    logic [13:0] px_w, py_w, left_w, top_w, right_w, bottom_w;
    logic        in_win, on_frame, in_strip, accept;
    logic [3:0]  strip_h;
    logic [11:0] rx, ry;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        px_w     = {2'b00, pixel_x};
        py_w     = {2'b00, pixel_y};
        left_w   = {2'b00, win_cfg.left};
        top_w    = {2'b00, win_cfg.top};
        right_w  = left_w + {1'b0, win_cfg.width};
        bottom_w = top_w + {1'b0, win_cfg.height};

        in_win   = (px_w >= left_w) && (py_w >= top_w) &&
                   (px_w < right_w) && (py_w < bottom_w);
        on_frame = (pixel_x == win_cfg.left) || (pixel_y == win_cfg.top) ||
                   (px_w == right_w - 14'd1) || (py_w == bottom_w - 14'd1);

        rx = pixel_x - win_cfg.left - 12'd1;
        ry = pixel_y - win_cfg.top - 12'd1;

        strip_h  = (inner_h > wsps_pkg::STRIP_LIMIT) ? wsps_pkg::STRIP_FULL
                                                     : 4'(inner_h >> 1);
        in_strip = (ry < {8'd0, strip_h});

        q_item.x      = pixel_x;
        q_item.y      = pixel_y;
        q_item.rend   = region_end;
        q_item.tidx   = texel_index;
        q_item.rx     = rx;
        q_item.ry     = ry;
        q_item.op     = wsps_pkg::OP_TEXEL;
        q_item.colour = texel_colour;

        if (kind == wsps_pkg::KIND_LOAD)
        begin
            q_item.op = wsps_pkg::OP_LOAD;
        end
        else if (on_frame)
        begin
            q_item.op     = wsps_pkg::OP_FLAT;
            q_item.colour = win_cfg.focused ? win_cfg.focus : win_cfg.border;
        end
        else if (in_strip)
        begin
            q_item.op     = wsps_pkg::OP_FLAT;
            q_item.colour = win_cfg.focused ? wsps_pkg::STRIP_LIGHT : wsps_pkg::STRIP_DARK;
        end

        // Drop shade items outside the window here.
        q_push = accept && ((kind == wsps_pkg::KIND_LOAD) || in_win);
    end

endmodule

>>> rtl/core/wsps_back.sv
`timescale 1ns / 1ps
// Back part: scaling dividers, surface store access and result assembly.
module wsps_back #(
    parameter int SURF_COLS = 48,
    parameter int SURF_ROWS = 32,
    parameter int OUT_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [12:0]          inner_w,
    input  logic [12:0]          inner_h,
    input  logic                 q_empty,
    input  wsps_pkg::mid_item_t  q_item,
    output logic                 q_pop,
    output logic                 res_push,
    output wsps_pkg::res_t       res_item,
    input  logic                 res_pop
);

    localparam int MAXD  = (SURF_COLS > SURF_ROWS) ? SURF_COLS : SURF_ROWS;
    localparam int QW    = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int CW    = 13 + QW;
    localparam int DEPTH = SURF_COLS * SURF_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(OUT_DEPTH + 1);

    // Issue and result credit
    logic [RW-1:0] rsv_reg, rsv_next;
    logic          issue;

    // Divider pipeline, stage 0 loaded at issue
    logic [QW:0]          vld_reg;
    wsps_pkg::mid_item_t  item_reg [0:QW];
    logic [CW-1:0]        remx_reg [0:QW];
    logic [CW-1:0]        remy_reg [0:QW];
    logic [QW-1:0]        qx_reg   [0:QW];
    logic [QW-1:0]        qy_reg   [0:QW];
    logic [CW-1:0]        remx_next [0:QW-1];
    logic [CW-1:0]        remy_next [0:QW-1];
    logic [QW-1:0]        qx_next   [0:QW-1];
    logic [QW-1:0]        qy_next   [0:QW-1];

    // Address stage and store stage
    logic                 vld_i_reg, vld_m_reg;
    wsps_pkg::mid_item_t  item_i_reg, item_m_reg;
    logic [AW-1:0]        idx_i_reg, idx_next;
    logic                 wen_i_reg, wen_next;
    logic [23:0]          rd_data_reg;
    logic [23:0]          store_mem [0:DEPTH-1];

    assign issue = !q_empty && (rsv_reg < RW'(OUT_DEPTH));
    assign q_pop = issue;

    always_comb
    begin
        rsv_next = rsv_reg;
        if (issue && (q_item.op != wsps_pkg::OP_LOAD) && !res_pop)
        begin
            rsv_next = rsv_reg + 1'b1;
        end
        else if (!(issue && (q_item.op != wsps_pkg::OP_LOAD)) && res_pop)
        begin
            rsv_next = rsv_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsv_reg   <= '0;
            vld_reg   <= '0;
            vld_i_reg <= 1'b0;
            vld_m_reg <= 1'b0;
        end
        else
        begin
            rsv_reg   <= rsv_next;
            vld_reg   <= {vld_reg[QW-1:0], issue};
            vld_i_reg <= vld_reg[QW];
            vld_m_reg <= vld_i_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg[0] <= q_item;
        remx_reg[0] <= CW'(q_item.rx) * CW'(SURF_COLS);
        remy_reg[0] <= CW'(q_item.ry) * CW'(SURF_ROWS);
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = QW - 1 - k;
        logic [CW-1:0] dx, dy;
        logic          gex, gey;

        always_comb
        begin
            dx           = CW'(inner_w) << B;
            dy           = CW'(inner_h) << B;
            gex          = (remx_reg[k] >= dx);
            gey          = (remy_reg[k] >= dy);
            remx_next[k] = gex ? (remx_reg[k] - dx) : remx_reg[k];
            remy_next[k] = gey ? (remy_reg[k] - dy) : remy_reg[k];
            qx_next[k]   = qx_reg[k] | (QW'(gex) << B);
            qy_next[k]   = qy_reg[k] | (QW'(gey) << B);
        end

        always_ff @(posedge clk)
        begin
            item_reg[k+1] <= item_reg[k];
            remx_reg[k+1] <= remx_next[k];
            remy_reg[k+1] <= remy_next[k];
            qx_reg[k+1]   <= qx_next[k];
            qy_reg[k+1]   <= qy_next[k];
        end
    end

    always_comb
    begin
        if (item_reg[QW].op == wsps_pkg::OP_LOAD)
        begin
            idx_next = AW'(item_reg[QW].tidx);
            wen_next = (32'(item_reg[QW].tidx) < DEPTH);
        end
        else
        begin
            idx_next = AW'(qy_reg[QW]) * AW'(SURF_COLS) + AW'(qx_reg[QW]);
            wen_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_i_reg <= item_reg[QW];
        idx_i_reg  <= idx_next;
        wen_i_reg  <= wen_next;
        item_m_reg <= item_i_reg;
    end

    // Loads write and shades read at the same stage, so accesses keep item order.
    always_ff @(posedge clk)
    begin
        if (vld_i_reg && wen_i_reg)
        begin
            store_mem[idx_i_reg] <= item_i_reg.colour;
        end
        rd_data_reg <= store_mem[idx_i_reg];
    end

    always_comb
    begin
        res_push        = vld_m_reg && (item_m_reg.op != wsps_pkg::OP_LOAD);
        res_item.x      = item_m_reg.x;
        res_item.y      = item_m_reg.y;
        res_item.rend   = item_m_reg.rend;
        res_item.colour = (item_m_reg.op == wsps_pkg::OP_FLAT) ? item_m_reg.colour
                                                               : rd_data_reg;
    end

    // Result credit never overcommits the result queue.
    assert property (@(posedge clk) disable iff (!rst_n) rsv_reg <= RW'(OUT_DEPTH))
        else $error("result credit beyond queue depth");

    // A finished division leaves a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[QW] && (item_reg[QW].op == wsps_pkg::OP_TEXEL)) |->
        ((remx_reg[QW] < CW'(inner_w)) && (remy_reg[QW] < CW'(inner_h))))
        else $error("scaling division did not converge");

    // A result leaves the store stage only for an item that was issued earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (rsv_reg != '0))
        else $error("result without reserved credit");

endmodule

>>> rtl/core/window_surface_pixel_shader.sv
`timescale 1ns / 1ps
// Top level of the window surface pixel shader: config registers and queues.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     push / full        kind, texel_index, texel_colour, pixel_x, pixel_y, region_end
//  result    empty / pop        out_x, out_y, out_colour, out_region_end
//  config    cfg_write          cfg_index (register number), cfg_data
//
// One item is accepted per clock while the front queue is not full. A result
// passes through the front queue, QW restoring-division stages (QW = bits of
// the larger surface dimension, 6 by default), address stage and store read.
// Reset clears control state only; the surface store holds garbage until
// loaded. The front stalls only when its queue fills; the back issues from
// that queue while the result queue has a free credit, so a stalled reader
// backs up into full without losing items.
module window_surface_pixel_shader #(
    parameter int SURF_COLS = 48,
    parameter int SURF_ROWS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [10:0] texel_index,
    input  logic [23:0] texel_colour,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic        region_end,

    output logic        empty,
    input  logic        pop,
    output logic [11:0] out_x,
    output logic [11:0] out_y,
    output logic [23:0] out_colour,
    output logic        out_region_end,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int MAXD      = (SURF_COLS > SURF_ROWS) ? SURF_COLS : SURF_ROWS;
    localparam int QW        = (MAXD > 1) ? $clog2(MAXD) : 1;
    // Room for every result in flight plus slack, rounded up to a power of two
    localparam int OUT_DEPTH = 1 << $clog2(QW + 4);
    localparam int MID_DEPTH = 4;

    wsps_pkg::win_cfg_t  cfg_reg, cfg_next;
    logic [12:0]         inner_w, inner_h;

    logic                q_push, q_full, q_pop, q_empty;
    wsps_pkg::mid_item_t q_wr_item, q_rd_item;

    logic                res_push, res_full, res_pop;
    wsps_pkg::res_t      res_wr_item, res_rd_item;

    // Configuration registers: decode the index, hold everything else.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (wsps_pkg::cfg_reg_t'(cfg_index))
                wsps_pkg::REG_WIN_LEFT:      cfg_next.left    = cfg_data[11:0];
                wsps_pkg::REG_WIN_TOP:       cfg_next.top     = cfg_data[11:0];
                wsps_pkg::REG_WIN_WIDTH:     cfg_next.width   = cfg_data[12:0];
                wsps_pkg::REG_WIN_HEIGHT:    cfg_next.height  = cfg_data[12:0];
                wsps_pkg::REG_IS_FOCUSED:    cfg_next.focused = cfg_data[0];
                wsps_pkg::REG_BORDER_COLOUR: cfg_next.border  = cfg_data;
                wsps_pkg::REG_FOCUS_COLOUR:  cfg_next.focus   = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left    <= '0;
            cfg_reg.top     <= '0;
            cfg_reg.width   <= 13'd2;
            cfg_reg.height  <= 13'd2;
            cfg_reg.focused <= 1'b0;
            cfg_reg.border  <= '0;
            cfg_reg.focus   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Inner area sizes; only used for pixels strictly inside the frame,
    // where the window is at least three pixels each way.
    assign inner_w = cfg_reg.width - 13'd2;
    assign inner_h = cfg_reg.height - 13'd2;

    // Front: clip and classify, drop pixels outside the window.
    wsps_front u_front (
        .push         (push),
        .full         (full),
        .kind         (kind),
        .texel_index  (texel_index),
        .texel_colour (texel_colour),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .region_end   (region_end),
        .win_cfg      (cfg_reg),
        .inner_h      (inner_h),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_wr_item)
    );

    // Decoupling queue between classification and the scaling pipeline.
    wsps_fifo #(
        .WIDTH ($bits(wsps_pkg::mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wr_item),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rd_item),
        .empty (q_empty)
    );

    // Back: divide for nearest-neighbor scaling, access the surface store.
    wsps_back #(
        .SURF_COLS (SURF_COLS),
        .SURF_ROWS (SURF_ROWS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .inner_w  (inner_w),
        .inner_h  (inner_h),
        .q_empty  (q_empty),
        .q_item   (q_rd_item),
        .q_pop    (q_pop),
        .res_push (res_push),
        .res_item (res_wr_item),
        .res_pop  (res_pop)
    );

    // Result queue: the reader sees the oldest item while empty is low.
    assign res_pop = pop && !empty;

    wsps_fifo #(
        .WIDTH ($bits(wsps_pkg::res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wr_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rd_item),
        .empty (empty)
    );

    assign out_x          = res_rd_item.x;
    assign out_y          = res_rd_item.y;
    assign out_colour     = res_rd_item.colour;
    assign out_region_end = res_rd_item.rend;

    // The credit scheme must never push a result into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into full result queue");

endmodule
